// ===== rtl/core/oets_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_pkg: shared definitions for the odd-even transposition sorter
// Sizes of the key chain, the key type and the control word of one cell.
// ----------------------------------------------------------------------------
package oets_pkg;

	localparam int MAX_ITEMS = 16;
	localparam int KEY_W     = 32;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W     = $clog2(MAX_ITEMS);

	typedef logic signed [KEY_W-1:0] key_t;

	// Per-cell control word.
	typedef struct packed {
		logic wr;      // capture the incoming key
		logic shift;   // take the right neighbour's key (draining)
		logic pair_r;  // compare-exchange with the right neighbour
		logic pair_l;  // compare-exchange with the left neighbour
	} cell_ctrl_t;

endpackage

// ===== rtl/core/odd_even_transposition_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter_core: collecting sorter for signed keys
// Gathers a set of keys into a row of cells, sorts it by odd-even
// transposition and sends the keys out in ascending order.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | handshake
//  --------+----------------------------------+---------------------
//  input   | key, final_item                  | in_valid / in_stall
//  output  | sorted_key, end_of_run, dropped  | out_valid / out_stall
//
// Keys are taken one per cycle while in_stall is low. The marked key starts
// MAX_ITEMS sort phases, one phase per cycle across the cell row, and then
// the held keys drain from the left-hand cell at one per cycle unless the
// output is stalled. in_stall is high while a set is being sorted or sent.
// Reset clears the control state; the cell contents need no reset.
// ----------------------------------------------------------------------------
module odd_even_transposition_sorter_core
	import oets_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] key,
	input  logic        final_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sorted_key,
	output logic        end_of_run,
	output logic        dropped
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SORT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [IDX_W-1:0] phase_q;
	logic             out_valid_q;
	key_t             sorted_key_q;
	logic             end_q;
	logic             dropped_q;

	logic in_xfer;
	logic room;
	logic sorting;
	logic out_free;
	logic emit_step;

	key_t       cell_key [MAX_ITEMS];
	cell_ctrl_t cell_ctrl [MAX_ITEMS];

	assign in_stall  = (state_q != ST_LOAD);
	assign in_xfer   = in_valid && !in_stall;
	assign room      = count_q < CNT_W'(MAX_ITEMS);
	assign sorting   = (state_q == ST_SORT);
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_step = (state_q == ST_EMIT) && out_free;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			localparam logic PAR = 1'(gi % 2);
			key_t left_k;
			key_t right_k;

			assign cell_ctrl[gi].wr     = in_xfer && room && (count_q == CNT_W'(gi));
			assign cell_ctrl[gi].shift  = emit_step;
			assign cell_ctrl[gi].pair_r = sorting && (phase_q[0] == PAR)
				&& (CNT_W'(gi + 1) < count_q);

			if (gi == 0) begin : g_first
				assign cell_ctrl[gi].pair_l = 1'b0;
				assign left_k               = '0;
			end else begin : g_inner
				assign cell_ctrl[gi].pair_l = sorting && (phase_q[0] != PAR)
					&& (CNT_W'(gi) < count_q);
				assign left_k               = cell_key[gi-1];
			end

			if (gi == MAX_ITEMS - 1) begin : g_last
				assign right_k = '0;
			end else begin : g_mid
				assign right_k = cell_key[gi+1];
			end

			oets_cell u_cell (
				.clk       (clk),
				.ctrl      (cell_ctrl[gi]),
				.in_key    (key),
				.left_key  (left_k),
				.right_key (right_k),
				.key_q     (cell_key[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= emit_step;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (final_item) begin
							state_q <= ST_SORT;
							phase_q <= '0;
						end
					end
				end
				ST_SORT: begin
					phase_q <= phase_q + IDX_W'(1);
					if (phase_q == IDX_W'(MAX_ITEMS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_step) begin
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							state_q <= ST_LOAD;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// The left-hand cell always holds the smallest key still to be sent.
	always_ff @(posedge clk) begin
		if (emit_step) begin
			sorted_key_q <= cell_key[0];
			end_q        <= (count_q == CNT_W'(1));
			dropped_q    <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sorted_key = sorted_key_q;
	assign end_of_run = end_q;
	assign dropped    = dropped_q;

endmodule

// ===== rtl/core/oets_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_cell: one key cell of the sorting chain
// Holds one key; loads, drains leftwards or exchanges with a neighbour.
// ----------------------------------------------------------------------------
module oets_cell
	import oets_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  key_t       in_key,
	input  key_t       left_key,
	input  key_t       right_key,
	output key_t       key_q
);

	logic right_less;
	logic left_greater;

	// Both cells of a pair evaluate the same comparison, so they swap together.
	assign right_less   = key_q > right_key;
	assign left_greater = left_key > key_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			key_q <= in_key;
		end else if (ctrl.shift) begin
			key_q <= right_key;
		end else if (ctrl.pair_r && right_less) begin
			key_q <= right_key;
		end else if (ctrl.pair_l && left_greater) begin
			key_q <= left_key;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the odd-even transposition sorter core
// Sends sets of signed keys, each closed by a key marked final, and works out
// the sorted output of every set, including the dropped flag for sets that
// overflow the store. Each output transfer is checked field by field against
// the oldest sorted key still due. Both sides idle at random, and one phase
// holds the output off for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import oets_pkg::*;

	localparam int   WAIT_MAX     = 19;
	localparam int   IDLE_LIMIT   = 3000;
	localparam int   DRAIN_CYCLES = 2 * MAX_ITEMS + 8;
	localparam int   LONG_HOLD    = 300;
	localparam int   PRINT_MAX    = 60;
	localparam key_t KEY_MIN      = {1'b1, {(KEY_W - 1){1'b0}}};
	localparam key_t KEY_MAX      = {1'b0, {(KEY_W - 1){1'b1}}};

	typedef struct {
		key_t key;
		logic last;
		logic lost;
	} sorted_entry_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] key;
	logic        final_item;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] sorted_key;
	logic        end_of_run;
	logic        dropped;

	// Keys of the set being collected, and what the sorter owes us.
	key_t          held_keys [MAX_ITEMS];
	int            held_n     = 0;
	bit            keys_lost  = 1'b0;
	sorted_entry_t sorted_due [$];

	int fail_count   = 0;
	int quiet_cycles = 0;
	int rx_wait      = 0;
	int rx_hold      = 0;
	bit tx_idle_on   = 1'b0;
	bit rx_idle_on   = 1'b0;

	odd_even_transposition_sorter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.key        (key),
		.final_item (final_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sorted_key (sorted_key),
		.end_of_run (end_of_run),
		.dropped    (dropped)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Adds one key to the set; on the final key, sorts the set by odd-even
	// transposition and queues every held key in ascending order.
	task automatic collect_key(input key_t k, input logic fin);
		key_t          swap_key;
		sorted_entry_t entry;
		if (held_n < MAX_ITEMS) begin
			held_keys[held_n] = k;
			held_n++;
		end else begin
			keys_lost = 1'b1;
		end
		if (fin) begin
			for (int ph = 0; ph < MAX_ITEMS; ph++) begin
				for (int i = ph % 2; i + 1 < held_n; i += 2) begin
					if (held_keys[i] > held_keys[i + 1]) begin
						swap_key         = held_keys[i];
						held_keys[i]     = held_keys[i + 1];
						held_keys[i + 1] = swap_key;
					end
				end
			end
			for (int i = 0; i < held_n; i++) begin
				entry.key  = held_keys[i];
				entry.last = (i == held_n - 1);
				entry.lost = keys_lost;
				sorted_due.push_back(entry);
			end
			held_n    = 0;
			keys_lost = 1'b0;
		end
	endtask

	task automatic check_result();
		sorted_entry_t want;
		if (sorted_due.size() == 0) begin
			fail_count++;
			if (fail_count <= PRINT_MAX)
				$display("%0t: unexpected transfer, expected none, got key %0d end %b dropped %b",
					$time, $signed(sorted_key), end_of_run, dropped);
		end else begin
			want = sorted_due.pop_front();
			if (sorted_key !== want.key) begin
				fail_count++;
				if (fail_count <= PRINT_MAX)
					$display("%0t: sorted_key expected %0d, got %0d",
						$time, want.key, $signed(sorted_key));
			end
			if (end_of_run !== want.last) begin
				fail_count++;
				if (fail_count <= PRINT_MAX)
					$display("%0t: end_of_run expected %b, got %b",
						$time, want.last, end_of_run);
			end
			if (dropped !== want.lost) begin
				fail_count++;
				if (fail_count <= PRINT_MAX)
					$display("%0t: dropped expected %b, got %b", $time, want.lost, dropped);
			end
		end
		rx_wait = rx_idle_on ? $urandom_range(0, WAIT_MAX) : 0;
	endtask

	// Watches both channels at the rising edge: predicts on every input
	// transfer, checks every output transfer and guards against a hang.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && !in_stall)
				collect_key(key_t'(key), final_item);
			if (out_valid && !out_stall)
				check_result();
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("[odd_even_transposition_sorter_core] ERROR");
				$finish;
			end
		end
	end

	// Receiver: a long hold-off takes precedence over the per-transfer wait.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else if (rx_wait > 0) begin
			out_stall <= 1'b1;
			rx_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic key_t pick_key();
		case ($urandom_range(0, 7))
			0:       return KEY_MIN;
			1:       return KEY_MAX;
			2, 3:    return key_t'($urandom_range(0, 8)) - 4;
			default: return key_t'($urandom);
		endcase
	endfunction

	// Entered and left at a falling edge. Valid stays high after a transfer,
	// so a caller that lets time pass must lower it first.
	task automatic send_key(input key_t k, input logic fin);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, WAIT_MAX) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		key        <= k;
		final_item <= fin;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			send_key(pick_key(), i == n - 1);
	endtask

	task automatic test_single_key();
		send_key(KEY_MIN, 1'b1);
	endtask

	task automatic test_extremes_and_ties();
		send_key(KEY_MAX, 1'b0);
		send_key(KEY_MIN, 1'b0);
		send_key(key_t'(0), 1'b0);
		send_key(key_t'(-1), 1'b0);
		send_key(KEY_MAX, 1'b0);
		send_key(KEY_MIN, 1'b1);
	endtask

	// Fills the store in descending order; the final key then finds no room.
	task automatic test_overflow();
		for (int i = 0; i < MAX_ITEMS; i++)
			send_key(key_t'(MAX_ITEMS - 1 - i), 1'b0);
		send_key(KEY_MAX, 1'b1);
	endtask

	task automatic test_random_sets(input int n_keys, input bit tx_on, input bit rx_on);
		int sent;
		int n;
		sent       = 0;
		tx_idle_on = tx_on;
		rx_idle_on = rx_on;
		while (sent < n_keys) begin
			if ($urandom_range(0, 7) == 0)
				n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
			else
				n = $urandom_range(1, MAX_ITEMS);
			send_set(n);
			sent += n;
		end
	endtask

	// The output is held off while sets of MAX_ITEMS - 2 to MAX_ITEMS + 2 keys
	// arrive back to back, so the sorter has to stall its input until hold-off ends.
	task automatic test_back_pressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		rx_hold = LONG_HOLD;
		@(negedge clk);
		repeat (3)
			send_set($urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 2));
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		key        = '0;
		final_item = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		test_single_key();
		test_extremes_and_ties();
		test_overflow();
		test_random_sets(120, 1'b0, 1'b0);
		test_random_sets(200, 1'b1, 1'b1);
		test_random_sets(80, 1'b1, 1'b0);
		test_back_pressure();
		test_random_sets(60, 1'b0, 1'b1);

		in_valid <= 1'b0;
		while (sorted_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[odd_even_transposition_sorter_core] OK");
		else
			$display("[odd_even_transposition_sorter_core] ERROR");
		$finish;
	end

endmodule

// ===== odd_even_transposition_sorter_core.f =====
rtl/core/oets_pkg.sv
rtl/core/oets_cell.sv
rtl/core/odd_even_transposition_sorter_core.sv
sim/tb_top.sv
